// ===== rtl/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Binaural speaker downmix package
// Shared sizes, payload structs, register indexes and small helper functions
// for the binaural speaker downmix block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

  // Storage dimensions.
  localparam int DELAY_DEPTH  = 64;
  localparam int MAX_CHANNELS = 8;
  localparam int MAX_SPEAKERS = 8;

  localparam int PTR_W     = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int MEM_DEPTH = MAX_CHANNELS * DELAY_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SPK_W     = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1;
  localparam int CH_CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int SPK_CNT_W = $clog2(MAX_SPEAKERS + 1);

  // Field widths of the transaction payloads.
  localparam int IDX_W       = 3;
  localparam int DLY_FIELD_W = 6;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int CNT_REG_W   = 4;

  // Datapath widths.
  localparam int STATE_W      = 24;
  localparam int MUL_A_W      = 25;
  localparam int MUL_P_W      = MUL_A_W + COEF_W + 1;
  localparam int ACC_W        = 40 + SPK_W;
  localparam int ACC_LO_W     = 24;
  localparam int ACC_HI_W     = ACC_W - ACC_LO_W;
  localparam int FULL_W       = ACC_W + COEF_W + 1;
  localparam int SMOOTH_SHIFT = 15;
  localparam int OUT_SHIFT    = 38;

  localparam logic [COEF_W-1:0] UNITY = COEF_W'(32768);

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_SPEAKER_COUNT = 2'd1;
  localparam logic [1:0] REG_OUTPUT_GAIN   = 2'd2;

  localparam logic [CNT_REG_W-1:0] CHANNEL_COUNT_RST = CNT_REG_W'(2);
  localparam logic [CNT_REG_W-1:0] SPEAKER_COUNT_RST = CNT_REG_W'(0);
  localparam logic [COEF_W-1:0]    OUTPUT_GAIN_RST   = COEF_W'(16384);

  // Command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef struct packed {
    logic                       command;
    logic [IDX_W-1:0]           index;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           source_channel;
    logic [DLY_FIELD_W-1:0]     delay_left;
    logic [DLY_FIELD_W-1:0]     delay_right;
    logic [COEF_W-1:0]          gain_left;
    logic [COEF_W-1:0]          gain_right;
    logic [COEF_W-1:0]          smooth_left;
    logic [COEF_W-1:0]          smooth_right;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } out_t;

  // Effective (clamped) configuration handed to the sequencer.
  typedef struct packed {
    logic [CH_CNT_W-1:0]  chans;
    logic [SPK_CNT_W-1:0] spk;
    logic [COEF_W-1:0]    out_gain;
  } cfg_t;

  // Coefficients above unity are clipped to unity.
  function automatic logic [COEF_W-1:0] sat_unity(input logic [COEF_W-1:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  // Delay reduced modulo the delay depth, as a small constant table.
  function automatic logic [PTR_W-1:0] dly_mod(input logic [DLY_FIELD_W-1:0] d);
    logic [PTR_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << DLY_FIELD_W); i++) begin
      if (d == DLY_FIELD_W'(i)) begin
        r = PTR_W'(i % DELAY_DEPTH);
      end
    end
    return r;
  endfunction

  // Address of one sample: lines of DELAY_DEPTH entries, one per channel.
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] ch,
                                                 input logic [PTR_W-1:0] pos);
    return ADDR_W'(int'(ch) * DELAY_DEPTH + int'(pos));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bsd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/bsd_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed operand times unsigned coefficient, product registered every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_mul import bsd_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic signed [MUL_A_W-1:0] a_i,
  input  wire logic [COEF_W-1:0]         b_i,
  output      logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_d;

  // The coefficient is zero extended so the product stays signed.
  assign p_d = MUL_P_W'(a_i * $signed({1'b0, b_i}));

  always_ff @(posedge clk_i) begin
    p_o <= p_d;
  end

endmodule

`default_nettype wire

// ===== rtl/bsd_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for channel count, speaker count and output gain.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_cfg import bsd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready,
  output      cfg_t                  cfg_o
);

  logic [CNT_REG_W-1:0] chan_cnt_q;
  logic [CNT_REG_W-1:0] spk_cnt_q;
  logic [COEF_W-1:0]    out_gain_q;
  logic [1:0]           reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= CHANNEL_COUNT_RST;
      spk_cnt_q  <= SPEAKER_COUNT_RST;
      out_gain_q <= OUTPUT_GAIN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CHANNEL_COUNT: chan_cnt_q <= pwdata[CNT_REG_W-1:0];
        REG_SPEAKER_COUNT: spk_cnt_q  <= pwdata[CNT_REG_W-1:0];
        REG_OUTPUT_GAIN:   out_gain_q <= sat_unity(pwdata[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_CHANNEL_COUNT: prdata = CFG_DATA_W'(chan_cnt_q);
      REG_SPEAKER_COUNT: prdata = CFG_DATA_W'(spk_cnt_q);
      REG_OUTPUT_GAIN:   prdata = CFG_DATA_W'(out_gain_q);
      default:           prdata = '0;
    endcase
  end

  // Clamp the counts to what the storage supports.
  always_comb begin
    if (chan_cnt_q == '0) begin
      cfg_o.chans = CH_CNT_W'(1);
    end else if (int'(chan_cnt_q) > MAX_CHANNELS) begin
      cfg_o.chans = CH_CNT_W'(MAX_CHANNELS);
    end else begin
      cfg_o.chans = CH_CNT_W'(chan_cnt_q);
    end
    if (int'(spk_cnt_q) > MAX_SPEAKERS) begin
      cfg_o.spk = SPK_CNT_W'(MAX_SPEAKERS);
    end else begin
      cfg_o.spk = SPK_CNT_W'(spk_cnt_q);
    end
    cfg_o.out_gain = out_gain_q;
  end

endmodule

`default_nettype wire

// ===== rtl/binaural_speaker_downmix.sv =====
// ----------------------------------------------------------------------------
// Binaural speaker downmix
// Renders interleaved speaker channels to a stereo headphone pair with a
// per-ear delay, one-pole smoothing and gain for every speaker entry.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                     Payload
// input     in_valid_i / in_ready_o       in_data_i  (in_t)
// output    out_valid_o / out_ready_i     out_data_o (out_t)
// config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// Speaker loads and non-final channel samples only update storage.
// The last channel of a frame starts a render over every active speaker: per
// ear a tap read, smoothing product, state update, gain product and accumulate,
// then output scaling (low product, high product, round) per ear and a hand-over.
// After reset the delay memory clears all MEM_DEPTH (512) entries, during
// which no input transaction is taken.
// A render whose result finds the output register still full waits there
// until the previous result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module binaural_speaker_downmix import bsd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire in_t                   in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      out_t                  out_data_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_RD   = 10'b0000000010,
    ST_SMUL = 10'b0000000100,
    ST_UPD  = 10'b0000001000,
    ST_GMUL = 10'b0000010000,
    ST_ACC  = 10'b0000100000,
    ST_OLO  = 10'b0001000000,
    ST_OHI  = 10'b0010000000,
    ST_ORND = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_e;

  localparam logic signed [MUL_P_W-1:0] SMOOTH_HALF = MUL_P_W'(1) <<< (SMOOTH_SHIFT - 1);
  localparam logic signed [FULL_W-1:0]  OUT_HALF    = FULL_W'(1) <<< (OUT_SHIFT - 1);
  localparam logic signed [FULL_W-1:0]  OUT_MAX     = FULL_W'(32'sd32767);
  localparam logic signed [FULL_W-1:0]  OUT_MIN     = FULL_W'(-32'sd32768);

  cfg_t cfg;

  state_e state_q, state_d;
  logic [SPK_W-1:0] k_q, k_d;
  logic             ear_q, ear_d;
  logic [PTR_W-1:0] wp_q;
  logic [ADDR_W:0]  clr_cnt_q;
  logic             clearing;

  // Speaker entry tables (contents undefined until loaded).
  logic [IDX_W-1:0]  src_q    [MAX_SPEAKERS];
  logic [PTR_W-1:0]  dly_q    [2][MAX_SPEAKERS];
  logic [COEF_W-1:0] gain_q   [2][MAX_SPEAKERS];
  logic [COEF_W-1:0] smooth_q [2][MAX_SPEAKERS];
  logic signed [STATE_W-1:0] filt_q [2][MAX_SPEAKERS];

  logic signed [ACC_W-1:0]    acc_q [2];
  logic signed [MUL_P_W-1:0]  plo_q;
  logic signed [SAMPLE_W-1:0] res_q [2];
  logic                       out_valid_q;
  out_t                       out_data_q;

  logic in_fire, is_sample, ch_ok, last_ch, samp_we, load_we, render_go;
  logic out_free;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0]   ram_wdata, ram_rdata;
  logic [PTR_W-1:0]      tap_dly, tap_pos;

  logic signed [SAMPLE_W-1:0] tap_x;
  logic signed [STATE_W-1:0]  s_old, s_new;
  logic signed [MUL_A_W-1:0]  diff;
  logic signed [MUL_P_W-1:0]  prod, rnd_sum, rnd_full;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic [COEF_W-1:0]          mul_b;
  logic signed [FULL_W-1:0]   full, out_sum, out_v;
  logic signed [SAMPLE_W-1:0] out_sat;

  bsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input decode.
  assign clearing   = clr_cnt_q < (ADDR_W + 1)'(MEM_DEPTH);
  assign in_ready_o = !clearing && (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_sample  = in_data_i.command == CMD_SAMPLE;
  assign ch_ok      = int'(in_data_i.index) < int'(cfg.chans);
  assign last_ch    = int'(in_data_i.index) == int'(cfg.chans) - 1;
  assign samp_we    = in_fire && is_sample && ch_ok;
  assign render_go  = samp_we && last_ch;
  assign load_we    = in_fire && !is_sample && (int'(in_data_i.index) < MAX_SPEAKERS);
  assign out_free   = !out_valid_q || out_ready_i;

  // Delay memory: cleared after reset, then written by channel samples.
  assign ram_we    = clearing || samp_we;
  assign ram_waddr = clearing ? clr_cnt_q[ADDR_W-1:0] : mem_addr(in_data_i.index, wp_q);
  assign ram_wdata = clearing ? '0 : in_data_i.sample;

  // Tap position behind the write position, wrapping around the line.
  assign tap_dly   = dly_q[ear_q][k_q];
  assign tap_pos   = (wp_q >= tap_dly) ? (wp_q - tap_dly)
                   : PTR_W'({1'b0, wp_q} + (PTR_W + 1)'(DELAY_DEPTH) - {1'b0, tap_dly});
  assign ram_raddr = mem_addr(src_q[k_q], tap_pos);

  bsd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One-pole filter update: s + round(c * ((x << 8) - s) / 2^15).
  assign tap_x    = (int'(src_q[k_q]) < MAX_CHANNELS) ? $signed(ram_rdata) : '0;
  assign s_old    = filt_q[ear_q][k_q];
  assign diff     = MUL_A_W'($signed({tap_x, 8'h00})) - MUL_A_W'(s_old);
  assign rnd_sum  = prod + SMOOTH_HALF;
  assign rnd_full = rnd_sum >>> SMOOTH_SHIFT;
  assign s_new    = s_old + STATE_W'(rnd_full);

  // Operand select for the shared multiplier.
  always_comb begin
    case (state_q)
      ST_SMUL: begin
        mul_a = diff;
        mul_b = smooth_q[ear_q][k_q];
      end
      ST_GMUL: begin
        // The filter state was updated at the previous edge.
        mul_a = MUL_A_W'(s_old);
        mul_b = gain_q[ear_q][k_q];
      end
      ST_OLO: begin
        mul_a = $signed({1'b0, acc_q[ear_q][ACC_LO_W-1:0]});
        mul_b = cfg.out_gain;
      end
      ST_OHI: begin
        mul_a = MUL_A_W'($signed(acc_q[ear_q][ACC_W-1:ACC_LO_W]));
        mul_b = cfg.out_gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bsd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Output scaling: recombine the split product, round and saturate.
  assign full    = (FULL_W'(prod) <<< ACC_LO_W) + FULL_W'(plo_q);
  assign out_sum = full + OUT_HALF;
  assign out_v   = out_sum >>> OUT_SHIFT;
  assign out_sat = (out_v > OUT_MAX) ? 16'sh7fff
                 : (out_v < OUT_MIN) ? 16'sh8000 : out_v[SAMPLE_W-1:0];

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ear_d   = ear_q;
    case (state_q)
      ST_IDLE: begin
        if (render_go) begin
          k_d     = '0;
          ear_d   = 1'b0;
          state_d = (cfg.spk == '0) ? ST_OLO : ST_RD;
        end
      end
      ST_RD:   state_d = ST_SMUL;
      ST_SMUL: state_d = ST_UPD;
      ST_UPD:  state_d = ST_GMUL;
      ST_GMUL: state_d = ST_ACC;
      ST_ACC: begin
        if (!ear_q) begin
          ear_d   = 1'b1;
          state_d = ST_RD;
        end else if (int'(k_q) + 1 < int'(cfg.spk)) begin
          ear_d   = 1'b0;
          k_d     = k_q + SPK_W'(1);
          state_d = ST_RD;
        end else begin
          ear_d   = 1'b0;
          state_d = ST_OLO;
        end
      end
      ST_OLO:  state_d = ST_OHI;
      ST_OHI:  state_d = ST_ORND;
      ST_ORND: begin
        if (!ear_q) begin
          ear_d   = 1'b1;
          state_d = ST_OLO;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      ear_q       <= 1'b0;
      wp_q        <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ear_q   <= ear_d;
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + (ADDR_W + 1)'(1);
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        wp_q <= (int'(wp_q) == DELAY_DEPTH - 1) ? '0 : wp_q + PTR_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Filter state: cleared by reset and by loading its entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < 2; e++) begin
        for (int s = 0; s < MAX_SPEAKERS; s++) begin
          filt_q[e][s] <= '0;
        end
      end
    end else if (load_we) begin
      filt_q[0][SPK_W'(in_data_i.index)] <= '0;
      filt_q[1][SPK_W'(in_data_i.index)] <= '0;
    end else if (state_q == ST_UPD) begin
      filt_q[ear_q][k_q] <= s_new;
    end
  end

  // Speaker entry tables.
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      src_q[SPK_W'(in_data_i.index)]       <= in_data_i.source_channel;
      dly_q[0][SPK_W'(in_data_i.index)]    <= dly_mod(in_data_i.delay_left);
      dly_q[1][SPK_W'(in_data_i.index)]    <= dly_mod(in_data_i.delay_right);
      gain_q[0][SPK_W'(in_data_i.index)]   <= sat_unity(in_data_i.gain_left);
      gain_q[1][SPK_W'(in_data_i.index)]   <= sat_unity(in_data_i.gain_right);
      smooth_q[0][SPK_W'(in_data_i.index)] <= sat_unity(in_data_i.smooth_left);
      smooth_q[1][SPK_W'(in_data_i.index)] <= sat_unity(in_data_i.smooth_right);
    end
  end

  // Datapath registers: ear sums, low partial product and results.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && render_go) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
    end else if (state_q == ST_ACC) begin
      acc_q[ear_q] <= acc_q[ear_q] + ACC_W'(prod);
    end
    if (state_q == ST_OHI) begin
      plo_q <= prod;
    end
    if (state_q == ST_ORND) begin
      res_q[ear_q] <= out_sat;
    end
    if (state_q == ST_DONE && out_free) begin
      out_data_q.left_sample  <= res_q[0];
      out_data_q.right_sample <= res_q[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The write position moves only when a result is handed over.
  a_wp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q != $past(wp_q)) |-> ($past(state_q) == ST_DONE))
    else $error("write position moved outside result hand-over");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wp_q) < DELAY_DEPTH)
    else $error("write position beyond delay depth");

  // A finished render lands in the output register and frees the input.
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_o && state_q == ST_IDLE))
    else $error("finished render did not produce a result");

  // Only the last channel sample of a frame starts a render.
  a_render_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && state_d != ST_IDLE) |-> render_go)
    else $error("render started without a final channel sample");

endmodule

`default_nettype wire

// ===== tb/tb_binaural_speaker_downmix.sv =====
// ----------------------------------------------------------------------------
// Binaural speaker downmix testbench
// Drives speaker loads and channel samples into the downmix block and checks
// each stereo pair against a cycle-free model of the same fixed-point math.
// The sender works in bursts and the receiver stalls on its own pattern.
// The register port is rewritten between phases once the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_binaural_speaker_downmix;
  import bsd_pkg::*;

  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 100;
  localparam int QUIET_LIMIT     = 5000;
  localparam int RANDOM_PHASES   = 13;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int REPORT_LIMIT    = 10;

  // Clock, reset and the ports of the block.
  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  binaural_speaker_downmix uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stimulus waiting for the driver and stereo pairs waiting for the block.
  in_t  pending_q[$];
  out_t stereo_q[$];

  int error_count     = 0;
  int items_accepted  = 0;
  int loads_accepted  = 0;
  int pairs_checked   = 0;
  int settings_count  = 0;

  // Shadow of the block's registers and storage.
  logic [CNT_REG_W-1:0] cfg_channels = CHANNEL_COUNT_RST;
  logic [CNT_REG_W-1:0] cfg_speakers = SPEAKER_COUNT_RST;
  int                   cfg_gain     = int'(OUTPUT_GAIN_RST);

  int               line_mem [MAX_CHANNELS][DELAY_DEPTH];
  logic [PTR_W-1:0] wr_pos = '0;
  logic [IDX_W-1:0] spk_src [MAX_SPEAKERS];
  logic [PTR_W-1:0] spk_dly_l [MAX_SPEAKERS];
  logic [PTR_W-1:0] spk_dly_r [MAX_SPEAKERS];
  int               spk_gain_l [MAX_SPEAKERS];
  int               spk_gain_r [MAX_SPEAKERS];
  int               spk_coef_l [MAX_SPEAKERS];
  int               spk_coef_r [MAX_SPEAKERS];
  int               filt_l [MAX_SPEAKERS];
  int               filt_r [MAX_SPEAKERS];

  initial begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      for (int p = 0; p < DELAY_DEPTH; p++) begin
        line_mem[c][p] = 0;
      end
    end
    for (int k = 0; k < MAX_SPEAKERS; k++) begin
      filt_l[k] = 0;
      filt_r[k] = 0;
    end
  end

  // Fixed-point helpers.
  function automatic int clip_unity(input logic [COEF_W-1:0] v);
    return (v > COEF_W'(32768)) ? 32768 : int'(v);
  endfunction

  // Round half up: add half an LSB, then floor by arithmetic shift.
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic int one_pole(input int st, input int x, input int c);
    longint diff;
    diff = longint'(x) * 256 - longint'(st);
    return int'(longint'(st) + round_shift(longint'(c) * diff, SMOOTH_SHIFT));
  endfunction

  function automatic logic [SAMPLE_W-1:0] scale_ear(input longint acc, input int gain);
    longint v;
    v = round_shift(acc * longint'(gain), OUT_SHIFT);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  // Apply one accepted transaction to the shadow state and queue any pair.
  task automatic predict_downmix(input in_t it);
    int               chans;
    int               spk;
    int               xl;
    int               xr;
    longint           acc_l;
    longint           acc_r;
    logic [PTR_W-1:0] pos_l;
    logic [PTR_W-1:0] pos_r;
    out_t             pair;
    if (it.command == CMD_LOAD) begin
      spk_src[it.index]    = it.source_channel;
      spk_dly_l[it.index]  = PTR_W'(it.delay_left);
      spk_dly_r[it.index]  = PTR_W'(it.delay_right);
      spk_gain_l[it.index] = clip_unity(it.gain_left);
      spk_gain_r[it.index] = clip_unity(it.gain_right);
      spk_coef_l[it.index] = clip_unity(it.smooth_left);
      spk_coef_r[it.index] = clip_unity(it.smooth_right);
      filt_l[it.index]     = 0;
      filt_r[it.index]     = 0;
      loads_accepted++;
      return;
    end
    chans = (cfg_channels == 0) ? 1 : int'(cfg_channels);
    if (chans > MAX_CHANNELS) chans = MAX_CHANNELS;
    if (int'(it.index) >= chans) return;
    line_mem[it.index][wr_pos] = int'($signed(it.sample));
    if (int'(it.index) != chans - 1) return;

    // Last channel of the frame: render every active speaker entry.
    spk = (int'(cfg_speakers) > MAX_SPEAKERS) ? MAX_SPEAKERS : int'(cfg_speakers);
    acc_l = 0;
    acc_r = 0;
    for (int k = 0; k < spk; k++) begin
      pos_l = PTR_W'(wr_pos - spk_dly_l[k]);
      pos_r = PTR_W'(wr_pos - spk_dly_r[k]);
      xl = line_mem[spk_src[k]][pos_l];
      xr = line_mem[spk_src[k]][pos_r];
      filt_l[k] = one_pole(filt_l[k], xl, spk_coef_l[k]);
      filt_r[k] = one_pole(filt_r[k], xr, spk_coef_r[k]);
      acc_l += longint'(spk_gain_l[k]) * longint'(filt_l[k]);
      acc_r += longint'(spk_gain_r[k]) * longint'(filt_r[k]);
    end
    pair.left_sample  = scale_ear(acc_l, cfg_gain);
    pair.right_sample = scale_ear(acc_r, cfg_gain);
    stereo_q.push_back(pair);
    wr_pos = wr_pos + 1'b1;
  endtask

  // Driver: bursts of transactions separated by random gaps.
  logic drv_valid;
  int   burst_left = 1;
  int   gap_left   = 0;

  function automatic int pick_gap();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(1, 3);
      2:       return $urandom_range(1, 12);
      default: return $urandom_range(12, 40);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      drv_valid = in_valid;
      if (in_valid && in_ready) begin
        predict_downmix(in_data);
        items_accepted++;
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          in_data <= pending_q.pop_front();
          drv_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = pick_gap();
          end
        end
      end
      in_valid <= drv_valid;
    end
  end

  // Monitor: compare each stereo transaction with the oldest prediction.
  out_t        want;
  logic [31:0] ready_bits = 32'hFFFF_FFFF;
  int          pattern_left = 32;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (stereo_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("unexpected stereo pair L=%0d R=%0d",
                     $signed(out_data.left_sample), $signed(out_data.right_sample));
          end
        end else begin
          want = stereo_q.pop_front();
          pairs_checked++;
          if (out_data.left_sample !== want.left_sample ||
              out_data.right_sample !== want.right_sample) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("pair %0d mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                       pairs_checked, $signed(want.left_sample),
                       $signed(want.right_sample), $signed(out_data.left_sample),
                       $signed(out_data.right_sample));
            end
          end
        end
      end
      // A fresh stall pattern once the old one runs out; bit 0 is never a stall.
      if (pattern_left == 0) begin
        case ($urandom_range(0, 2))
          0:       ready_bits = 32'hFFFF_FFFF;
          1:       ready_bits = $urandom | 32'h1;
          default: ready_bits = ($urandom & $urandom) | 32'h1;
        endcase
        pattern_left = 32;
      end
      out_ready <= ready_bits[0];
      ready_bits = {ready_bits[0], ready_bits[31:1]};
      pattern_left--;
    end
  end

  // Watchdog: too long without any transaction ends the run.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus builders.
  function automatic in_t noise_item();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_t)-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_W'(32768);
      1:       return COEF_W'(0);
      2:       return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic in_t sample_item(input int ch, input logic [SAMPLE_W-1:0] value);
    in_t it;
    it = noise_item();
    it.command = CMD_SAMPLE;
    it.index   = IDX_W'(ch);
    it.sample  = value;
    return it;
  endfunction

  function automatic in_t load_item(input int entry, input int src, input int dl,
                                    input int dr, input logic [COEF_W-1:0] gl,
                                    input logic [COEF_W-1:0] gr,
                                    input logic [COEF_W-1:0] sl,
                                    input logic [COEF_W-1:0] sr);
    in_t it;
    it = noise_item();
    it.command        = CMD_LOAD;
    it.index          = IDX_W'(entry);
    it.source_channel = IDX_W'(src);
    it.delay_left     = DLY_FIELD_W'(dl);
    it.delay_right    = DLY_FIELD_W'(dr);
    it.gain_left      = gl;
    it.gain_right     = gr;
    it.smooth_left    = sl;
    it.smooth_right   = sr;
    return it;
  endfunction

  function automatic in_t random_load();
    return load_item($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 63),
                     $urandom_range(0, 63), pick_coef(), pick_coef(), pick_coef(),
                     pick_coef());
  endfunction

  // One frame: in order (style 0), a skipped channel (1), a repeated channel
  // (2), or only the last channel (3).
  task automatic add_frame(input int chans, input int style, inout int added);
    int pick;
    pick = $urandom_range(0, chans - 1);
    for (int ch = 0; ch < chans; ch++) begin
      if (style == 1 && ch == pick && ch != chans - 1) continue;
      if (style == 3 && ch != chans - 1) continue;
      pending_q.push_back(sample_item(ch, pick_sample()));
      added++;
      if (style == 2 && ch == pick) begin
        pending_q.push_back(sample_item(ch, pick_sample()));
        added++;
      end
    end
  endtask

  // Wait until the block has drained, then give it time to finish a render.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid || stereo_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] reg_sel, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({reg_sel, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    // The register takes the value at this edge.
    case (reg_sel)
      REG_CHANNEL_COUNT: cfg_channels = value[CNT_REG_W-1:0];
      REG_SPEAKER_COUNT: cfg_speakers = value[CNT_REG_W-1:0];
      REG_OUTPUT_GAIN:   cfg_gain     = clip_unity(value[COEF_W-1:0]);
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Upper bits of the write data are junk half of the time.
  task automatic configure(input logic [3:0] ch_raw, input logic [3:0] spk_raw,
                           input logic [15:0] gain_raw);
    logic [31:0] junk;
    wait_idle();
    junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'h0;
    write_register(REG_CHANNEL_COUNT, {junk[31:4], ch_raw});
    junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'h0;
    write_register(REG_SPEAKER_COUNT, {junk[31:4], spk_raw});
    junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'h0;
    write_register(REG_OUTPUT_GAIN, {junk[31:16], gain_raw});
    settings_count++;
  endtask

  task automatic run_random_phase(input logic [3:0] ch_raw, input logic [3:0] spk_raw,
                                  input logic [15:0] gain_raw);
    int chans;
    int added;
    int r;
    configure(ch_raw, spk_raw, gain_raw);
    chans = (ch_raw == 0) ? 1 : int'(ch_raw);
    if (chans > MAX_CHANNELS) chans = MAX_CHANNELS;
    added = 0;
    while (added < ITEMS_PER_PHASE) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        add_frame(chans, 0, added);
      end else if (r < 88) begin
        add_frame(chans, $urandom_range(1, 3), added);
      end else if (r < 94 && chans < MAX_CHANNELS) begin
        // Unused channel: ignored by the block, not counted.
        pending_q.push_back(sample_item($urandom_range(chans, MAX_CHANNELS - 1),
                                        pick_sample()));
      end else begin
        pending_q.push_back(random_load());
        added++;
      end
    end
  endtask

  // Main sequence.
  logic [3:0]  rnd_ch;
  logic [3:0]  rnd_spk;
  logic [15:0] rnd_gain;

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block clears its delay memory before it takes any transaction.
    do @(negedge clk_i);
    while (!in_ready);

    // Reset settings, no speakers yet: frames render to silence.
    pending_q.push_back(sample_item(0, 16'h7FFF));
    pending_q.push_back(sample_item(1, 16'h8000));
    pending_q.push_back(sample_item(5, 16'h1234));
    pending_q.push_back(sample_item(1, 16'h0000));

    // Load every entry, with unity, zero and oversized coefficients.
    pending_q.push_back(load_item(0, 0, 0, 63, 16'd32768, 16'd0, 16'd32768, 16'd32768));
    pending_q.push_back(load_item(1, 1, 63, 0, 16'hFFFF, 16'd32768, 16'hFFFF, 16'd0));
    pending_q.push_back(load_item(2, 7, 1, 2, 16'd16384, 16'd16384, 16'd16384, 16'h8001));
    pending_q.push_back(load_item(3, 3, 5, 9, 16'd32768, 16'd32768, 16'd32768, 16'd32768));
    pending_q.push_back(load_item(4, 4, 0, 0, 16'd32768, 16'd32768, 16'd1, 16'd32767));
    for (int k = 5; k < MAX_SPEAKERS; k++) begin
      pending_q.push_back(load_item(k, k, $urandom_range(0, 63), $urandom_range(0, 63),
                                    pick_coef(), pick_coef(), pick_coef(), pick_coef()));
    end

    // All channels and speakers at unity output gain, full-scale samples.
    configure(4'd8, 4'd8, 16'd32768);
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      pending_q.push_back(sample_item(ch, (ch % 2 == 0) ? 16'h7FFF : 16'h8000));
    end
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      pending_q.push_back(sample_item(ch, 16'h7FFF));
    end
    pending_q.push_back(sample_item(7, 16'h8000));

    // Out-of-range and extreme settings first, then random ones.
    run_random_phase(4'd0, 4'd15, 16'hFFFF);
    run_random_phase(4'd15, 4'd0, 16'd0);
    run_random_phase(4'd1, 4'd1, 16'd32768);
    run_random_phase(4'd8, 4'd8, 16'd1);
    for (int p = 0; p < RANDOM_PHASES - 4; p++) begin
      rnd_ch   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
      rnd_spk  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
      rnd_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom) : pick_coef();
      run_random_phase(rnd_ch, rnd_spk, rnd_gain);
    end

    wait_idle();
    if (stereo_q.size() != 0) begin
      error_count++;
      $display("%0d predicted stereo pairs never arrived", stereo_q.size());
    end
    $display("Accepted %0d input transactions (%0d speaker loads) under %0d settings.",
             items_accepted, loads_accepted, settings_count + 1);
    $display("Checked %0d stereo pairs, %0d mismatches.", pairs_checked, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
